FILE: src/cckb_pkg.sv
// Shared constants and types for the clipped color-key blitter.
package cckb_pkg;

    localparam int MAX_DIM_DEF = 2048;
    localparam int COORD_W     = 16;
    localparam int ADDR_W      = 22;
    localparam int PIXEL_W     = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 80;

    typedef enum logic [1:0] {
        ST_STARTED  = 2'd0,
        ST_NOTHING  = 2'd1,
        ST_NO_SCALE = 2'd2,
        ST_STEP     = 2'd3
    } status_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEST_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_RECT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RECT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR  = 3'd6;

endpackage

FILE: src/clipped_color_key_blitter.sv
// Clipped color-key blit engine: start/clip logic, pixel walk and result register.
//
// A start beat latches the destination rectangle clipped to the destination surface and
// answers with one result: started (with the first source address to fetch, or zero when
// filling), nothing to do, or scaling unsupported. Each following step beat carries the
// source pixel fetched at the announced address and yields one destination write result;
// tlast marks the final pixel or a start that starts no walk. The block sustains one beat
// per clock while the output side is not stalled: a beat is held in the input register and
// then moves to the result register, which drives m_tvalid and m_tdata until the result is
// taken. Both address products (row times surface width) are formed in the single stage
// between the two registers.
module clipped_color_key_blitter #(
    parameter int MAX_DIM = cckb_pkg::MAX_DIM_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [cckb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cckb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cckb_pkg::IN_DATA_W-1:0]   s_tdata,   // src_pixel[31:0]
    input  logic                             s_tuser,   // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], write_enable[2], dest_address[24:3], write_data[56:25],
    // next_src_address[78:57], zero pad [79]
    output logic [cckb_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CW     = cckb_pkg::COORD_W;
    localparam int AW     = cckb_pkg::ADDR_W;
    localparam int PW0    = CW + DIM_W + 1;
    localparam int PROD_W = (PW0 > AW) ? PW0 : AW;

    // Configuration registers.
    logic [31:0]                      dest_size_reg, source_size_reg;
    logic [63:0]                      dest_rect_reg, source_rect_reg;
    logic [1:0]                       mode_reg;
    logic [cckb_pkg::PIXEL_W-1:0]     key_color_reg, fill_color_reg;

    // Input register.
    logic                             in_valid_reg;
    logic                             in_op_reg;
    logic [cckb_pkg::PIXEL_W-1:0]     in_pixel_reg;

    // Walk state.
    logic                             active_reg, active_next;
    logic [DIM_W-1:0]                 clip_left_reg, clip_left_next;
    logic [DIM_W-1:0]                 clip_right_reg, clip_right_next;
    logic [DIM_W-1:0]                 clip_bottom_reg, clip_bottom_next;
    logic [DIM_W-1:0]                 dest_col_reg, dest_col_next;
    logic [DIM_W-1:0]                 dest_row_reg, dest_row_next;
    logic [CW-1:0]                    src_col_reg, src_col_next;
    logic [CW-1:0]                    src_row_reg, src_row_next;
    logic [CW-1:0]                    src_row_start_col_reg, src_row_start_col_next;

    // Result register.
    logic                             out_valid_reg;
    cckb_pkg::status_t                status_reg, status_next;
    logic                             we_reg, we_next;
    logic [AW-1:0]                    daddr_reg, daddr_next;
    logic [cckb_pkg::PIXEL_W-1:0]     wdata_reg, wdata_next;
    logic [AW-1:0]                    naddr_reg, naddr_next;
    logic                             last_reg, last_next;

    logic                             adv;
    logic                             fill;
    logic [DIM_W-1:0]                 dw_surf, dh_surf, sw_surf;
    logic signed [CW-1:0]             dl, dt, dr, db, sl, st;
    logic signed [CW-1:0]             sr, sb;
    logic signed [CW:0]               src_w, src_h, dst_w, dst_h;
    logic signed [CW:0]               dw_s, dh_s, dl_c, dt_c, dr_c, db_c;
    logic                             src_empty, size_mismatch, dst_empty;
    logic [CW-1:0]                    sl_c, st_c;
    logic [DIM_W-1:0]                 dcol_inc, drow_inc;
    logic                             wrap, done, keyed;
    logic [CW-1:0]                    step_src_col, step_src_row;
    logic [CW-1:0]                    mul_row, mul_col;
    logic [PROD_W-1:0]                src_prod, dst_prod;
    logic [AW-1:0]                    src_addr, dst_addr;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign fill     = mode_reg[0];

    always_comb begin
        dw_surf = (dest_size_reg[15:0] > 16'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                       : dest_size_reg[DIM_W-1:0];
        dh_surf = (dest_size_reg[31:16] > 16'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                        : dest_size_reg[16+DIM_W-1:16];
        sw_surf = (source_size_reg[15:0] > 16'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                         : source_size_reg[DIM_W-1:0];
    end

    // Start decoding: size checks and clipping against the destination surface.
    always_comb begin
        dl = signed'(dest_rect_reg[15:0]);
        dt = signed'(dest_rect_reg[31:16]);
        dr = signed'(dest_rect_reg[47:32]);
        db = signed'(dest_rect_reg[63:48]);
        sl = signed'(source_rect_reg[15:0]);
        st = signed'(source_rect_reg[31:16]);
        sr = signed'(source_rect_reg[47:32]);
        sb = signed'(source_rect_reg[63:48]);
        src_w = 17'(sr) - 17'(sl);
        src_h = 17'(sb) - 17'(st);
        dst_w = 17'(dr) - 17'(dl);
        dst_h = 17'(db) - 17'(dt);
        src_empty     = (src_w <= 0) || (src_h <= 0);
        size_mismatch = (src_w != dst_w) || (src_h != dst_h);
        dw_s = signed'(17'(dw_surf));
        dh_s = signed'(17'(dh_surf));
        dl_c = dl[CW-1] ? '0 : 17'(dl);
        dt_c = dt[CW-1] ? '0 : 17'(dt);
        dr_c = (17'(dr) > dw_s) ? dw_s : 17'(dr);
        db_c = (17'(db) > dh_s) ? dh_s : 17'(db);
        dst_empty = (dr_c <= dl_c) || (db_c <= dt_c);
        sl_c = sl[CW-1] ? '0 : CW'(sl);
        st_c = st[CW-1] ? '0 : CW'(st);
    end

    // Pixel walk advance.
    always_comb begin
        dcol_inc     = dest_col_reg + 1'b1;
        drow_inc     = dest_row_reg + 1'b1;
        wrap         = dcol_inc >= clip_right_reg;
        done         = wrap && (drow_inc >= clip_bottom_reg);
        step_src_col = wrap ? src_row_start_col_reg : src_col_reg + 1'b1;
        step_src_row = wrap ? src_row_reg + 1'b1 : src_row_reg;
    end

    // Address products.
    always_comb begin
        mul_row  = (in_op_reg == cckb_pkg::OP_START) ? st_c : step_src_row;
        mul_col  = (in_op_reg == cckb_pkg::OP_START) ? sl_c : step_src_col;
        src_prod = PROD_W'(mul_row) * PROD_W'(sw_surf) + PROD_W'(mul_col);
        dst_prod = PROD_W'(dest_row_reg) * PROD_W'(dw_surf) + PROD_W'(dest_col_reg);
        src_addr = src_prod[AW-1:0];
        dst_addr = dst_prod[AW-1:0];
    end

    always_comb begin
        active_next            = active_reg;
        clip_left_next         = clip_left_reg;
        clip_right_next        = clip_right_reg;
        clip_bottom_next       = clip_bottom_reg;
        dest_col_next          = dest_col_reg;
        dest_row_next          = dest_row_reg;
        src_col_next           = src_col_reg;
        src_row_next           = src_row_reg;
        src_row_start_col_next = src_row_start_col_reg;
        status_next            = cckb_pkg::ST_STEP;
        we_next                = 1'b0;
        daddr_next             = '0;
        wdata_next             = '0;
        naddr_next             = '0;
        last_next              = 1'b0;
        keyed = mode_reg[1] && (in_pixel_reg == key_color_reg);
        if (in_op_reg == cckb_pkg::OP_START) begin
            active_next = 1'b0;
            if (!fill && src_empty) begin
                status_next = cckb_pkg::ST_NOTHING;
                last_next   = 1'b1;
            end else if (!fill && size_mismatch) begin
                status_next = cckb_pkg::ST_NO_SCALE;
                last_next   = 1'b1;
            end else if (dst_empty) begin
                status_next = cckb_pkg::ST_NOTHING;
                last_next   = 1'b1;
            end else begin
                active_next            = 1'b1;
                clip_left_next         = dl_c[DIM_W-1:0];
                clip_right_next        = dr_c[DIM_W-1:0];
                clip_bottom_next       = db_c[DIM_W-1:0];
                dest_col_next          = dl_c[DIM_W-1:0];
                dest_row_next          = dt_c[DIM_W-1:0];
                src_col_next           = sl_c;
                src_row_next           = st_c;
                src_row_start_col_next = sl_c;
                status_next            = cckb_pkg::ST_STARTED;
                naddr_next             = fill ? '0 : src_addr;
            end
        end else if (active_reg) begin
            we_next       = fill || !keyed;
            wdata_next    = fill ? fill_color_reg : (keyed ? '0 : in_pixel_reg);
            daddr_next    = dst_addr;
            dest_col_next = wrap ? clip_left_reg : dcol_inc;
            dest_row_next = wrap ? drow_inc : dest_row_reg;
            src_col_next  = step_src_col;
            src_row_next  = step_src_row;
            if (done) begin
                active_next = 1'b0;
                last_next   = 1'b1;
            end else if (!fill) begin
                naddr_next = src_addr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_size_reg   <= '0;
            source_size_reg <= '0;
            dest_rect_reg   <= '0;
            source_rect_reg <= '0;
            mode_reg        <= '0;
            key_color_reg   <= '0;
            fill_color_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cckb_pkg::CFG_DEST_SIZE:   dest_size_reg   <= cfg_wdata[31:0];
                cckb_pkg::CFG_SOURCE_SIZE: source_size_reg <= cfg_wdata[31:0];
                cckb_pkg::CFG_DEST_RECT:   dest_rect_reg   <= cfg_wdata;
                cckb_pkg::CFG_SOURCE_RECT: source_rect_reg <= cfg_wdata;
                cckb_pkg::CFG_MODE:        mode_reg        <= cfg_wdata[1:0];
                cckb_pkg::CFG_KEY_COLOR:   key_color_reg   <= cfg_wdata[31:0];
                cckb_pkg::CFG_FILL_COLOR:  fill_color_reg  <= cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_op_reg    <= s_tuser;
            in_pixel_reg <= s_tdata[cckb_pkg::PIXEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg            <= 1'b0;
            clip_left_reg         <= '0;
            clip_right_reg        <= '0;
            clip_bottom_reg       <= '0;
            dest_col_reg          <= '0;
            dest_row_reg          <= '0;
            src_col_reg           <= '0;
            src_row_reg           <= '0;
            src_row_start_col_reg <= '0;
        end else if (adv) begin
            active_reg            <= active_next;
            clip_left_reg         <= clip_left_next;
            clip_right_reg        <= clip_right_next;
            clip_bottom_reg       <= clip_bottom_next;
            dest_col_reg          <= dest_col_next;
            dest_row_reg          <= dest_row_next;
            src_col_reg           <= src_col_next;
            src_row_reg           <= src_row_next;
            src_row_start_col_reg <= src_row_start_col_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (adv) begin
            status_reg <= status_next;
            we_reg     <= we_next;
            daddr_reg  <= daddr_next;
            wdata_reg  <= wdata_next;
            naddr_reg  <= naddr_next;
            last_reg   <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, naddr_reg, wdata_reg, daddr_reg, we_reg, status_reg};
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_walk_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (clip_left_reg <= dest_col_reg) && (dest_col_reg < clip_right_reg)
                       && (dest_row_reg < clip_bottom_reg))
        else $error("blit walk position outside the clipped rectangle");

    a_last_ends_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_op_reg == cckb_pkg::OP_STEP && active_reg && done) |=> !active_reg)
        else $error("final pixel did not return the engine to idle");

    a_start_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && status_reg != cckb_pkg::ST_STEP) |-> !we_reg)
        else $error("start result carries a destination write");
`endif

endmodule
